>>> design/svr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svr_pkg
// Shared types and constants for the launch speed and wheel rpm pipeline.
// ----------------------------------------------------------------------------
package svr_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_HEIGHT_OFS = 3'd0;
   localparam logic [2:0] CSR_DIST_OFS   = 3'd1;
   localparam logic [2:0] CSR_TAN        = 3'd2;
   localparam logic [2:0] CSR_GRAVITY    = 3'd3;
   localparam logic [2:0] CSR_RPM_FACTOR = 3'd4;
   localparam logic [2:0] CSR_RPM_TRIM   = 3'd5;

   // one quotient bit per divider cell, two radicand bits per root cell
   localparam int DIV_STEPS  = 63;
   localparam int SQRT_STEPS = 32;

   // area scale, rpm scale (1000 mm/m times Q.8)
   localparam logic [13:0] AREA_SCALE = 14'd10000;
   localparam logic [53:0] RPM_SCALE  = 54'd256000;
   localparam logic [53:0] RPM_LIMIT  = 54'd65536 * RPM_SCALE;
   // ceil(2^30 / 125), exact floor for dividends below 2^23
   localparam logic [23:0] RECIP_125  = 24'd8589935;

   typedef struct packed {
      logic [10:0] height_ofs;
      logic [10:0] dist_ofs;
      logic [19:0] tan_angle;
      logic [23:0] gravity;
      logic [19:0] rpm_factor;
      logic [13:0] rpm_trim;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        nosol;
      logic [32:0] rem;
      logic [62:0] nq;     // dividend shifting out, quotient shifting in
      logic [32:0] den;
   } div_stage_type;

   typedef struct packed {
      logic        valid;
      logic        nosol;
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
   } sqrt_stage_type;

   typedef struct packed {
      logic [15:0] speed;
      logic [15:0] rpm;
      logic        nosol;
   } rsp_type;

endpackage
`default_nettype wire

>>> design/shot_velocity_and_wheel_rpm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shot_velocity_and_wheel_rpm
// Launch speed (mm/s) and flywheel rpm for a fixed exit angle.
//
// Requests (distance_cm, height_cm) arrive on req_valid/req_ready; one result
// (speed_mm_s, wheel_rpm, no_solution) leaves on rsp_valid/rsp_ready for each
// request, in order. Registers are written through csr_we/csr_index/csr_wdata
// and must only change while the pipeline is empty.
// Throughput: one request per cycle while the output queue is not full. The
// path runs through 6 front stages, a chain of 63 divider cells at one
// quotient bit each, 32 root cells at one root bit each, 3 rpm stages and the
// output queue.
// The whole chain advances together; a two-entry output queue lets it keep
// taking requests while one result waits. When the queue is full the chain
// holds and req_ready drops. Reset empties the pipeline and the queue and
// returns every register to its reset value.
// ----------------------------------------------------------------------------
module shot_velocity_and_wheel_rpm
   import svr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [11:0] req_distance_cm,
   input  wire logic [9:0]  req_height_cm,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_speed_mm_s,
   output logic [15:0]      rsp_wheel_rpm,
   output logic             rsp_no_solution,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    en;

   div_stage_type  div_chain  [DIV_STEPS+1];
   sqrt_stage_type sqrt_chain [SQRT_STEPS+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.height_ofs <= 11'd0;
         cfg_ff.dist_ofs   <= 11'd0;
         cfg_ff.tan_angle  <= 20'd65536;
         cfg_ff.gravity    <= 24'd655360;
         cfg_ff.rpm_factor <= 20'd65536;
         cfg_ff.rpm_trim   <= 14'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEIGHT_OFS: cfg_ff.height_ofs <= csr_wdata[10:0];
            CSR_DIST_OFS:   cfg_ff.dist_ofs   <= csr_wdata[10:0];
            CSR_TAN:        cfg_ff.tan_angle  <= csr_wdata[19:0];
            CSR_GRAVITY:    cfg_ff.gravity    <= csr_wdata[23:0];
            CSR_RPM_FACTOR: cfg_ff.rpm_factor <= csr_wdata[19:0];
            CSR_RPM_TRIM:   cfg_ff.rpm_trim   <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   assign req_ready = en;

   svr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_valid),
      .distance_cm (req_distance_cm),
      .height_cm   (req_height_cm),
      .cfg         (cfg_ff),
      .out         (div_chain[0])
   );

   // divider chain
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      svr_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .prev  (div_chain[i]),
         .next  (div_chain[i+1])
      );
   end

   // quotient becomes the radicand
   assign sqrt_chain[0].valid = div_chain[DIV_STEPS].valid;
   assign sqrt_chain[0].nosol = div_chain[DIV_STEPS].nosol;
   assign sqrt_chain[0].rad   = {1'b0, div_chain[DIV_STEPS].nq};
   assign sqrt_chain[0].rem   = '0;
   assign sqrt_chain[0].root  = '0;

   // square root chain
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      svr_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .prev  (sqrt_chain[j]),
         .next  (sqrt_chain[j+1])
      );
   end

   svr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in              (sqrt_chain[SQRT_STEPS]),
      .cfg             (cfg_ff),
      .en              (en),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_speed_mm_s  (rsp_speed_mm_s),
      .rsp_wheel_rpm   (rsp_wheel_rpm),
      .rsp_no_solution (rsp_no_solution)
   );

endmodule
`default_nettype wire

>>> design/svr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svr_front
// Offsets, denominator d*tan - h and numerator 10000*K*d^2, six stages.
// ----------------------------------------------------------------------------
module svr_front
   import svr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [11:0]   distance_cm,
   input  wire logic [9:0]    height_cm,
   input  wire cfg_type       cfg,
   output div_stage_type      out
);

   logic [5:0] valid_ff;

   logic signed [13:0] d_ff;
   logic signed [11:0] h1_ff, h2_ff;
   logic signed [34:0] dt_ff;
   logic [12:0]        ad_ff;
   logic signed [35:0] den_ff;
   logic [25:0]        ad2_ff;
   logic [39:0]        p_ff;
   logic [32:0]        den4_ff, den5_ff, den6_ff;
   logic               nos4_ff, nos5_ff, nos6_ff;
   logic [51:0]        pl_ff, ph_ff;
   logic [62:0]        num_ff;

   logic signed [13:0] d_in;
   logic signed [11:0] h_in;
   logic signed [20:0] tan_s;
   logic        [13:0] d_neg;
   logic signed [35:0] den_in;
   logic [63:0]        num_in;

   always_comb begin
      d_in   = {2'b00, distance_cm} + {{3{cfg.dist_ofs[10]}}, cfg.dist_ofs};
      h_in   = {2'b00, height_cm} - {cfg.height_ofs[10], cfg.height_ofs};
      tan_s  = {1'b0, cfg.tan_angle};
      d_neg  = -d_ff;
      den_in = {dt_ff[34], dt_ff} - {{8{h2_ff[11]}}, h2_ff, 16'h0000};
      num_in = {12'h000, pl_ff} + {ph_ff, 12'h000};
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         h1_ff   <= h_in;
         dt_ff   <= d_ff * tan_s;
         ad_ff   <= d_ff[13] ? d_neg[12:0] : d_ff[12:0];
         h2_ff   <= h1_ff;
         den_ff  <= den_in;
         ad2_ff  <= ad_ff * ad_ff;
         p_ff    <= ad2_ff * AREA_SCALE;
         nos4_ff <= den_ff[35] || (den_ff == '0);
         den4_ff <= den_ff[32:0];
         pl_ff   <= p_ff[37:0] * cfg.gravity[11:0];
         ph_ff   <= p_ff[37:0] * cfg.gravity[23:12];
         nos5_ff <= nos4_ff;
         den5_ff <= den4_ff;
         num_ff  <= num_in[62:0];
         nos6_ff <= nos5_ff;
         den6_ff <= den5_ff;
      end
   end

   assign out.valid = valid_ff[5];
   assign out.nosol = nos6_ff;
   assign out.rem   = '0;
   assign out.nq    = num_ff;
   assign out.den   = den6_ff;

endmodule
`default_nettype wire

>>> design/svr_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svr_div_cell
// One restoring division step: resolves one quotient bit.
// ----------------------------------------------------------------------------
module svr_div_cell
   import svr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire div_stage_type prev,
   output div_stage_type      next
);

   logic        valid_ff;
   logic        nosol_ff;
   logic [32:0] rem_ff;
   logic [62:0] nq_ff;
   logic [32:0] den_ff;

   logic [33:0] shifted;
   logic [33:0] diff;
   logic        ge;

   // shift in next dividend bit, subtract if it fits
   always_comb begin
      shifted = {prev.rem, prev.nq[62]};
      diff    = shifted - {1'b0, prev.den};
      ge      = shifted >= {1'b0, prev.den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nosol_ff <= prev.nosol;
         rem_ff   <= ge ? diff[32:0] : shifted[32:0];
         nq_ff    <= {prev.nq[61:0], ge};
         den_ff   <= prev.den;
      end
   end

   assign next.valid = valid_ff;
   assign next.nosol = nosol_ff;
   assign next.rem   = rem_ff;
   assign next.nq    = nq_ff;
   assign next.den   = den_ff;

endmodule
`default_nettype wire

>>> design/svr_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svr_sqrt_cell
// One digit-by-digit square root step: resolves one root bit.
// ----------------------------------------------------------------------------
module svr_sqrt_cell
   import svr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire sqrt_stage_type prev,
   output sqrt_stage_type      next
);

   logic        valid_ff;
   logic        nosol_ff;
   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;

   logic [35:0] shifted;
   logic [35:0] trial;
   logic [35:0] diff;
   logic        ge;

   // bring down two radicand bits, try root*4+1
   always_comb begin
      shifted = {prev.rem, prev.rad[63:62]};
      trial   = {2'b00, prev.root, 2'b01};
      diff    = shifted - trial;
      ge      = shifted >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nosol_ff <= prev.nosol;
         rad_ff   <= {prev.rad[61:0], 2'b00};
         rem_ff   <= ge ? diff[33:0] : shifted[33:0];
         root_ff  <= {prev.root[30:0], ge};
      end
   end

   assign next.valid = valid_ff;
   assign next.nosol = nosol_ff;
   assign next.rad   = rad_ff;
   assign next.rem   = rem_ff;
   assign next.root  = root_ff;

endmodule
`default_nettype wire

>>> design/svr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svr_back
// Speed saturation, rpm scaling with divide by 256000, two-entry output queue.
// ----------------------------------------------------------------------------
module svr_back
   import svr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire sqrt_stage_type in,
   input  wire cfg_type        cfg,
   output logic                en,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [15:0]         rsp_speed_mm_s,
   output logic [15:0]         rsp_wheel_rpm,
   output logic                rsp_no_solution
);

   logic [2:0]  valid_ff;
   logic [51:0] prod_ff;
   logic [15:0] spd1_ff, spd2_ff, spd3_ff;
   logic        nos1_ff, nos2_ff, nos3_ff;
   logic        zero2_ff, zero3_ff, max2_ff, max3_ff;
   logic [22:0] x_ff;
   logic [46:0] y_ff;

   rsp_type     e0_ff, e1_ff, e0_in, e1_in, item;
   logic [1:0]  cnt_ff, cnt_in;

   logic [53:0] dropx;
   logic [53:0] acc;
   logic        push, pop;

   always_comb begin
      dropx = {{40{cfg.rpm_trim[13]}}, cfg.rpm_trim} * RPM_SCALE;
      acc   = {2'b00, prod_ff} + dropx;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in.valid};
      end
   end

   // rpm datapath
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= in.root * cfg.rpm_factor;
         spd1_ff  <= (in.root[31:16] != '0) ? 16'hFFFF : in.root[15:0];
         nos1_ff  <= in.nosol;
         zero2_ff <= acc[53] || (acc == '0);
         max2_ff  <= !acc[53] && (acc >= RPM_LIMIT);
         x_ff     <= acc[33:11];
         spd2_ff  <= spd1_ff;
         nos2_ff  <= nos1_ff;
         y_ff     <= x_ff * RECIP_125;
         zero3_ff <= zero2_ff;
         max3_ff  <= max2_ff;
         spd3_ff  <= spd2_ff;
         nos3_ff  <= nos2_ff;
      end
   end

   // finished result
   always_comb begin
      item.nosol = nos3_ff;
      item.speed = nos3_ff ? 16'h0000 : spd3_ff;
      if (nos3_ff || zero3_ff) begin
         item.rpm = 16'h0000;
      end else if (max3_ff) begin
         item.rpm = 16'hFFFF;
      end else begin
         item.rpm = y_ff[45:30];
      end
   end

   // output queue, head in e0
   always_comb begin
      en     = (cnt_ff != 2'd2);
      push   = en && valid_ff[2];
      pop    = (cnt_ff != 2'd0) && rsp_ready;
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      cnt_in = cnt_ff;
      if (push && pop) begin
         e0_in = item;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            e0_in = item;
         end else begin
            e1_in = item;
         end
         cnt_in = cnt_ff + 2'd1;
      end else if (pop) begin
         e0_in  = e1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_speed_mm_s  = e0_ff.speed;
   assign rsp_wheel_rpm   = e0_ff.rpm;
   assign rsp_no_solution = e0_ff.nosol;

endmodule
`default_nettype wire

>>> tb/svr_checker.sv
// ----------------------------------------------------------------------------
// svr_checker
// Watches the request, result and csr ports of the launch speed block. It
// keeps its own copy of the registers, works out the expected result of each
// accepted request and compares every returned result, in order, field by
// field. It reports the failure count and the number of results still due.
// ----------------------------------------------------------------------------
module svr_checker
   import svr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [11:0] req_distance_cm,
   input  wire logic [9:0]  req_height_cm,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_speed_mm_s,
   input  wire logic [15:0] rsp_wheel_rpm,
   input  wire logic        rsp_no_solution,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata,
   output int               fail_count,
   output int               results_due,
   output int               results_seen,
   output int               nosol_seen
);

   cfg_type shadow_cfg;
   rsp_type launch_q[$];

   // floor of the square root, bit by bit
   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // expected speed, rpm and flag for one measurement
   function automatic rsp_type launch_solution(logic [11:0] dist_cm, logic [9:0] hgt);
      longint d;
      longint h;
      longint den;
      longint unsigned ad;
      longint unsigned num;
      longint unsigned s;
      longint acc;
      longint rpm;
      rsp_type r;
      d = longint'(dist_cm) + longint'($signed(shadow_cfg.dist_ofs));
      h = longint'(hgt) - longint'($signed(shadow_cfg.height_ofs));
      den = d * longint'(shadow_cfg.tan_angle) - h * 65536;
      r = '0;
      if (den <= 0) begin
         r.nosol = 1'b1;
         return r;
      end
      ad = (d < 0) ? longint'(-d) : longint'(d);
      num = 64'd10000 * (longint'(shadow_cfg.gravity) * (ad * ad));
      s = floor_sqrt(num / longint'(den));
      acc = longint'(s * longint'(shadow_cfg.rpm_factor))
            + longint'($signed(shadow_cfg.rpm_trim)) * 256000;
      rpm = 0;
      if (acc > 0) begin
         rpm = acc / 256000;
         if (rpm > 65535) rpm = 65535;
      end
      r.speed = (s > 65535) ? 16'hFFFF : s[15:0];
      r.rpm = rpm[15:0];
      return r;
   endfunction

   assign results_due = launch_q.size();

   always @(posedge clock) begin
      rsp_type exp_r;
      int errs;
      errs = 0;
      if (reset) begin
         shadow_cfg.height_ofs <= '0;
         shadow_cfg.dist_ofs <= '0;
         shadow_cfg.tan_angle <= 20'd65536;
         shadow_cfg.gravity <= 24'd655360;
         shadow_cfg.rpm_factor <= 20'd65536;
         shadow_cfg.rpm_trim <= '0;
         launch_q.delete();
         fail_count <= 0;
         results_seen <= 0;
         nosol_seen <= 0;
      end else begin
         // register mirror; unknown indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_HEIGHT_OFS: shadow_cfg.height_ofs <= csr_wdata[10:0];
               CSR_DIST_OFS:   shadow_cfg.dist_ofs <= csr_wdata[10:0];
               CSR_TAN:        shadow_cfg.tan_angle <= csr_wdata[19:0];
               CSR_GRAVITY:    shadow_cfg.gravity <= csr_wdata[23:0];
               CSR_RPM_FACTOR: shadow_cfg.rpm_factor <= csr_wdata[19:0];
               CSR_RPM_TRIM:   shadow_cfg.rpm_trim <= csr_wdata[13:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            launch_q.push_back(launch_solution(req_distance_cm, req_height_cm));
         // compare with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (rsp_no_solution) nosol_seen <= nosol_seen + 1;
            if (launch_q.size() == 0) begin
               $error("unexpected result: speed %0d rpm %0d no_solution %0b",
                      rsp_speed_mm_s, rsp_wheel_rpm, rsp_no_solution);
               errs++;
            end else begin
               exp_r = launch_q.pop_front();
               if (exp_r.speed !== rsp_speed_mm_s) begin
                  $error("speed_mm_s: expected %0d, got %0d", exp_r.speed, rsp_speed_mm_s);
                  errs++;
               end
               if (exp_r.rpm !== rsp_wheel_rpm) begin
                  $error("wheel_rpm: expected %0d, got %0d", exp_r.rpm, rsp_wheel_rpm);
                  errs++;
               end
               if (exp_r.nosol !== rsp_no_solution) begin
                  $error("no_solution: expected %0b, got %0b", exp_r.nosol,
                         rsp_no_solution);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

>>> tb/tb_shot_velocity_and_wheel_rpm.sv
// ----------------------------------------------------------------------------
// tb_shot_velocity_and_wheel_rpm
// Drives requests and register settings into the launch speed block with
// random idle and stall bursts; a separate checker predicts and compares.
// Directed corners first, then random requests under several settings.
// ----------------------------------------------------------------------------
module tb_shot_velocity_and_wheel_rpm;
   import svr_pkg::*;

   localparam int LATENCY = 110;
   localparam int CYCLE_LIMIT = 600000;
   // indexes with no register behind them
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_distance_cm = '0;
   logic [9:0]  req_height_cm = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_speed_mm_s;
   logic [15:0] rsp_wheel_rpm;
   logic        rsp_no_solution;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   int fail_count;
   int results_due;
   int results_seen;
   int nosol_seen;
   int cycles = 0;
   int settings_used = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   shot_velocity_and_wheel_rpm uut (.*);

   svr_checker u_checker (.*);

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side stalls in bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(1, 14) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one request, with an occasional idle burst ahead of it
   task automatic send_shot(logic [11:0] dist_cm, logic [9:0] hgt);
      bit taken;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_distance_cm <= dist_cm;
      req_height_cm <= hgt;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // stop sending and wait for an empty pipeline
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(logic [10:0] hofs, logic [10:0] dofs, logic [19:0] tanv,
                                logic [23:0] grav, logic [19:0] rf, logic [13:0] drop);
      drain();
      csr_write(CSR_HEIGHT_OFS, {13'd0, hofs});
      csr_write(CSR_DIST_OFS, {13'd0, dofs});
      csr_write(CSR_TAN, {4'd0, tanv});
      csr_write(CSR_GRAVITY, grav);
      csr_write(CSR_RPM_FACTOR, {4'd0, rf});
      csr_write(CSR_RPM_TRIM, {10'd0, drop});
      settings_used++;
   endtask

   // mostly solvable geometry, some arbitrary points
   task automatic random_shots(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_shot(12'($urandom_range(0, 4095)), 10'($urandom_range(0, 1023)));
         else
            send_shot(12'($urandom_range(200, 4095)), 10'($urandom_range(0, 400)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners at reset values
      send_shot(12'd0, 10'd0);          // zero denominator
      send_shot(12'd0, 10'd1023);       // height above line
      send_shot(12'd4095, 10'd0);
      send_shot(12'd4095, 10'd1023);
      send_shot(12'd1023, 10'd1023);    // d*tan equals h
      send_shot(12'd1024, 10'd1023);
      send_shot(12'd300, 10'd250);
      // unknown indexes must be ignored
      drain();
      csr_write(CSR_SPARE_LO, 24'hFFFFFF);
      csr_write(CSR_SPARE_HI, 24'hFFFFFF);
      send_shot(12'd500, 10'd100);

      // negative shifted distance, large negative rpm trim
      apply_setting(11'h400, 11'h400, 20'd65536, 24'd655360, 20'd65536, 14'h2000);
      send_shot(12'd0, 10'd0);
      send_shot(12'd100, 10'd0);
      send_shot(12'd4095, 10'd1023);
      send_shot(12'd1500, 10'd0);
      // speed and rpm overflow
      apply_setting(11'h3FF, 11'h3FF, 20'd1, 24'hFFFFFF, 20'hFFFFF, 14'h1FFF);
      send_shot(12'd4095, 10'd0);
      send_shot(12'd4095, 10'd1023);
      send_shot(12'd1, 10'd0);
      send_shot(12'd2000, 10'd1000);
      // zero gain registers, steep angle
      apply_setting(11'd0, 11'd0, 20'hFFFFF, 24'd0, 20'd0, 14'd0);
      send_shot(12'd4095, 10'd1023);
      send_shot(12'd1, 10'd0);

      // random phases under a spread of settings
      apply_setting(11'd0, 11'd0, 20'd65536, 24'd655360, 20'd65536, 14'd0);
      random_shots(120);
      apply_setting(11'($urandom), 11'($urandom), 20'($urandom_range(20000, 200000)),
                    24'($urandom_range(300000, 1500000)),
                    20'($urandom_range(10000, 200000)), 14'($urandom));
      random_shots(120);
      apply_setting(11'h7FF, 11'h001, 20'hFFFFF, 24'hFFFFFF, 20'hFFFFF, 14'h3FFF);
      random_shots(80);
      apply_setting(11'($urandom), 11'($urandom), 20'($urandom), 24'($urandom),
                    20'($urandom), 14'($urandom));
      random_shots(100);
      // full pause before the last phase
      drain();
      apply_setting(11'($urandom), 11'($urandom), 20'($urandom_range(30000, 120000)),
                    24'($urandom_range(400000, 900000)),
                    20'($urandom_range(20000, 90000)), 14'($urandom));
      random_shots(120);
      quiet = 1'b1;
      random_shots(100);

      drain();
      $display("covered %0d results (%0d without a solution) over %0d register settings",
               results_seen, nosol_seen, settings_used);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
